// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, constants and the control store of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int CMD_W     = 2;
  localparam int CH_W      = 8;
  localparam int RADDR_W   = 11;
  localparam int CURSOR_W  = 11;
  localparam int COLOR_W   = 4;
  localparam int CELL_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int STEP_W    = 4;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam logic [CH_W-1:0]    NEWLINE_CODE = 8'd10;
  localparam logic [CH_W-1:0]    SPACE_CODE   = 8'h20;
  localparam logic [COLOR_W-1:0] FG_RESET     = 4'hF;
  localparam logic [COLOR_W-1:0] BG_RESET     = 4'h1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR = 1'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [STEP_W-1:0] {
    ST_INIT, ST_CHAR, ST_NL, ST_SCROLL, ST_CPY_RD, ST_CPY_WR,
    ST_FILL, ST_CLEAR, ST_READ, ST_READ_OUT, ST_NOP
  } step_e;

  typedef enum logic [1:0] {AS_CURSOR, AS_COUNT, AS_COUNT_ROW, AS_READ} addr_sel_e;
  typedef enum logic [1:0] {WD_CHAR, WD_SPACE, WD_ZERO, WD_COPY} wdata_sel_e;
  typedef enum logic [1:0] {CNT_HOLD, CNT_CLEAR, CNT_INC} cnt_op_e;
  typedef enum logic [2:0] {CUR_HOLD, CUR_ADVANCE, CUR_NEWLINE, CUR_HOME, CUR_LAST_ROW} cur_op_e;
  typedef enum logic [1:0] {CND_AT_LAST_CELL, CND_ON_LAST_ROW, CND_COPY_END, CND_FILL_END} cond_e;
  typedef enum logic [1:0] {JMP_NEXT, JMP_ALWAYS, JMP_IF, JMP_UNLESS} jmp_e;
  typedef enum logic [1:0] {FIN_NONE, FIN_RESULT, FIN_QUIET} fin_e;

  typedef struct packed {
    logic       mem_we;
    logic       mem_re;
    addr_sel_e  addr_sel;
    wdata_sel_e wdata_sel;
    cnt_op_e    cnt_op;
    cur_op_e    cur_op;
    logic       res_cell;
    cond_e      cond;
    jmp_e       jmp;
    step_e      target;
    fin_e       fin;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    logic       busy;
    logic       accept;
    logic       mem_we;
    logic       mem_re;
    addr_sel_e  addr_sel;
    wdata_sel_e wdata_sel;
    cnt_op_e    cnt_op;
    cur_op_e    cur_op;
    logic       res_load;
    logic       res_cell;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic at_last_cell;
    logic on_last_row;
    logic copy_end;
    logic fill_end;
  } stat_t;

  function automatic ucode_t ucode_rom(step_e s);
    ucode_t u;
    u = '0;
    case (s)
      ST_INIT: begin
        // power-up clearing pass
        u.mem_we    = 1'b1;
        u.addr_sel  = AS_COUNT;
        u.wdata_sel = WD_ZERO;
        u.cnt_op    = CNT_INC;
        u.cond      = CND_FILL_END;
        u.jmp       = JMP_UNLESS;
        u.target    = ST_INIT;
        u.fin       = FIN_QUIET;
      end
      ST_CHAR: begin
        u.mem_we    = 1'b1;
        u.addr_sel  = AS_CURSOR;
        u.wdata_sel = WD_CHAR;
        u.cur_op    = CUR_ADVANCE;
        u.cond      = CND_AT_LAST_CELL;
        u.jmp       = JMP_IF;
        u.target    = ST_SCROLL;
        u.fin       = FIN_RESULT;
      end
      ST_NL: begin
        u.cur_op = CUR_NEWLINE;
        u.cond   = CND_ON_LAST_ROW;
        u.jmp    = JMP_IF;
        u.target = ST_SCROLL;
        u.fin    = FIN_RESULT;
      end
      ST_SCROLL: begin
        u.cnt_op = CNT_CLEAR;
        u.cur_op = CUR_LAST_ROW;
      end
      ST_CPY_RD: begin
        u.mem_re   = 1'b1;
        u.addr_sel = AS_COUNT_ROW;
      end
      ST_CPY_WR: begin
        u.mem_we    = 1'b1;
        u.addr_sel  = AS_COUNT;
        u.wdata_sel = WD_COPY;
        u.cnt_op    = CNT_INC;
        u.cond      = CND_COPY_END;
        u.jmp       = JMP_UNLESS;
        u.target    = ST_CPY_RD;
      end
      ST_FILL: begin
        u.mem_we    = 1'b1;
        u.addr_sel  = AS_COUNT;
        u.wdata_sel = WD_SPACE;
        u.cnt_op    = CNT_INC;
        u.cond      = CND_FILL_END;
        u.jmp       = JMP_UNLESS;
        u.target    = ST_FILL;
        u.fin       = FIN_RESULT;
      end
      ST_CLEAR: begin
        u.cnt_op = CNT_CLEAR;
        u.cur_op = CUR_HOME;
        u.jmp    = JMP_ALWAYS;
        u.target = ST_FILL;
      end
      ST_READ: begin
        u.mem_re   = 1'b1;
        u.addr_sel = AS_READ;
      end
      ST_READ_OUT: begin
        u.res_cell = 1'b1;
        u.fin      = FIN_RESULT;
      end
      ST_NOP: begin
        u.fin = FIN_RESULT;
      end
      default: begin
        u.fin = FIN_QUIET;
      end
    endcase
    return u;
  endfunction

  function automatic step_e entry_step(logic [CMD_W-1:0] cmd, logic [CH_W-1:0] ch);
    step_e s;
    case (cmd)
      CMD_WRITE: s = (ch == NEWLINE_CODE) ? ST_NL : ST_CHAR;
      CMD_CLEAR: s = ST_CLEAR;
      CMD_READ:  s = ST_READ;
      default:   s = ST_NOP;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/tcw_ifs.sv =====
// ----------------------------------------------------------------------------
// tcw channel interfaces
// Command, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tcw_in_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::CMD_W-1:0]   cmd;
  logic [tcw_pkg::CH_W-1:0]    ch;
  logic [tcw_pkg::RADDR_W-1:0] read_addr;

  modport source (output valid, cmd, ch, read_addr, input ready);
  modport sink (input valid, cmd, ch, read_addr, output ready);
endinterface

interface tcw_out_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::CURSOR_W-1:0] cursor_out;
  logic [tcw_pkg::CH_W-1:0]     cell_char;
  logic [tcw_pkg::COLOR_W-1:0]  cell_fg;
  logic [tcw_pkg::COLOR_W-1:0]  cell_bg;

  modport source (output valid, cursor_out, cell_char, cell_fg, cell_bg, input ready);
  modport sink (input valid, cursor_out, cell_char, cell_fg, cell_bg, output ready);
endinterface

interface tcw_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::CFG_IDX_W-1:0] index;
  logic [tcw_pkg::COLOR_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine over a Columns x Rows cell store.
// ----------------------------------------------------------------------------
// character: writes the cell at the cursor, advances the cursor, loads the result;
// newline: moves the cursor to the next row; read: registered store read; no word is
// taken while an item runs; scroll copies rows up and blanks the last row, clear
// blanks all cells; the single store port gives one cell read or write per step;
// after reset a clearing pass zeroes all Columns*Rows cells (2000 by default), so
// no word is taken before it ends; config writes are taken at all times
module text_console_writer #(
  parameter int Columns = tcw_pkg::DEF_COLUMNS,
  parameter int Rows    = tcw_pkg::DEF_ROWS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcw_in_if.sink    in_i,
  tcw_out_if.source out_o,
  tcw_cfg_if.sink   cfg_i
);

  logic [tcw_pkg::COLOR_W-1:0] fg_q;
  logic [tcw_pkg::COLOR_W-1:0] bg_q;
  tcw_pkg::ctrl_t              ctrl;
  tcw_pkg::stat_t              stat;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= tcw_pkg::FG_RESET;
      bg_q <= tcw_pkg::BG_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        tcw_pkg::REG_FG_COLOR: fg_q <= cfg_i.data;
        tcw_pkg::REG_BG_COLOR: bg_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  tcw_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_cmd_i    (in_i.cmd),
    .in_ch_i     (in_i.ch),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  tcw_datapath #(
    .Columns (Columns),
    .Rows    (Rows)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .in_ch_i        (in_i.ch),
    .in_read_addr_i (in_i.read_addr),
    .fg_i           (fg_q),
    .bg_i           (bg_q),
    .stat_o         (stat),
    .cursor_out_o   (out_o.cursor_out),
    .cell_char_o    (out_o.cell_char),
    .cell_fg_o      (out_o.cell_fg),
    .cell_bg_o      (out_o.cell_bg)
  );

endmodule

// ===== rtl/tcw_cell_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Single-port cell store with registered read data.
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
  parameter int Depth = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic                       re_i,
  input  logic [AddrW-1:0]           addr_i,
  input  logic [tcw_pkg::CELL_W-1:0] wdata_i,
  output logic [tcw_pkg::CELL_W-1:0] rdata_o
);

  logic [tcw_pkg::CELL_W-1:0] mem [Depth];
  logic [tcw_pkg::CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tcw_sequencer.sv =====
// ----------------------------------------------------------------------------
// tcw_sequencer
// Step counter over the control store, branch logic and result handshake.
// ----------------------------------------------------------------------------
module tcw_sequencer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [tcw_pkg::CMD_W-1:0] in_cmd_i,
  input  logic [tcw_pkg::CH_W-1:0]  in_ch_i,
  output logic                      in_ready_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  input  tcw_pkg::stat_t            stat_i,
  output tcw_pkg::ctrl_t            ctrl_o
);

  tcw_pkg::step_e  upc_q, upc_d;
  logic            busy_q, busy_d;
  logic            out_valid_q, out_valid_d;
  tcw_pkg::ucode_t uc;
  logic            cond;
  logic            taken;
  logic            finishing;
  logic            stall;
  logic            step_en;
  logic            accept;

  assign uc = tcw_pkg::ucode_rom(upc_q);

  always_comb begin
    case (uc.cond)
      tcw_pkg::CND_AT_LAST_CELL: cond = stat_i.at_last_cell;
      tcw_pkg::CND_ON_LAST_ROW:  cond = stat_i.on_last_row;
      tcw_pkg::CND_COPY_END:     cond = stat_i.copy_end;
      tcw_pkg::CND_FILL_END:     cond = stat_i.fill_end;
      default:                   cond = 1'b0;
    endcase
  end

  always_comb begin
    case (uc.jmp)
      tcw_pkg::JMP_ALWAYS: taken = 1'b1;
      tcw_pkg::JMP_IF:     taken = cond;
      tcw_pkg::JMP_UNLESS: taken = !cond;
      default:             taken = 1'b0;
    endcase
  end

  assign finishing = !taken && (uc.fin != tcw_pkg::FIN_NONE);
  // a result step waits until the output word is free
  assign stall   = finishing && (uc.fin == tcw_pkg::FIN_RESULT) && out_valid_q && !out_ready_i;
  assign step_en = busy_q && !stall;
  assign in_ready_o = !busy_q;
  assign accept  = in_valid_i && !busy_q;

  always_comb begin
    upc_d  = upc_q;
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
      upc_d  = tcw_pkg::entry_step(in_cmd_i, in_ch_i);
    end else if (step_en) begin
      if (taken) begin
        upc_d = uc.target;
      end else if (finishing) begin
        busy_d = 1'b0;
      end else begin
        upc_d = tcw_pkg::step_e'(upc_q + tcw_pkg::STEP_W'(1));
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step_en && finishing && (uc.fin == tcw_pkg::FIN_RESULT)) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= tcw_pkg::ST_INIT;
      busy_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    ctrl_o.busy      = busy_q;
    ctrl_o.accept    = accept;
    ctrl_o.mem_we    = step_en && uc.mem_we;
    ctrl_o.mem_re    = step_en && uc.mem_re;
    ctrl_o.addr_sel  = uc.addr_sel;
    ctrl_o.wdata_sel = uc.wdata_sel;
    ctrl_o.cnt_op    = step_en ? uc.cnt_op : tcw_pkg::CNT_HOLD;
    ctrl_o.cur_op    = step_en ? uc.cur_op : tcw_pkg::CUR_HOLD;
    ctrl_o.res_load  = step_en && finishing && (uc.fin == tcw_pkg::FIN_RESULT);
    ctrl_o.res_cell  = uc.res_cell;
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  // only a result step may be held back
  a_stall_only_at_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !step_en) |-> (finishing && out_valid_q))
    else $error("sequencer stalled outside a result step");
  // the power-up clearing pass produces no result
  a_init_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && upc_q == tcw_pkg::ST_INIT) |-> !out_valid_q)
    else $error("result during clearing pass");
  // a new result only comes from a running item
  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q)) |-> ($past(busy_q) && !busy_q))
    else $error("result without finishing item");
`endif

endmodule

// ===== rtl/tcw_datapath.sv =====
// ----------------------------------------------------------------------------
// tcw_datapath
// Cursor, sweep counter, cell store addressing and result word.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int Columns = tcw_pkg::DEF_COLUMNS,
  parameter int Rows    = tcw_pkg::DEF_ROWS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tcw_pkg::ctrl_t               ctrl_i,
  input  logic [tcw_pkg::CH_W-1:0]     in_ch_i,
  input  logic [tcw_pkg::RADDR_W-1:0]  in_read_addr_i,
  input  logic [tcw_pkg::COLOR_W-1:0]  fg_i,
  input  logic [tcw_pkg::COLOR_W-1:0]  bg_i,
  output tcw_pkg::stat_t               stat_o,
  output logic [tcw_pkg::CURSOR_W-1:0] cursor_out_o,
  output logic [tcw_pkg::CH_W-1:0]     cell_char_o,
  output logic [tcw_pkg::COLOR_W-1:0]  cell_fg_o,
  output logic [tcw_pkg::COLOR_W-1:0]  cell_bg_o
);

  localparam int Cells    = Columns * Rows;
  localparam int LastRow  = Cells - Columns;
  localparam int AddrW    = $clog2(Cells);
  localparam int CurW     = $clog2(Cells + 1);
  localparam int ColW     = $clog2(Columns);
  localparam int OutCurW  = tcw_pkg::CURSOR_W;

  logic [CurW-1:0]  cursor_q, cursor_d;
  logic [CurW-1:0]  row_q, row_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [AddrW-1:0] cnt_q, cnt_d;
  logic [tcw_pkg::CH_W-1:0] ch_q;
  logic [AddrW-1:0] raddr_q;
  logic             rd_ok_q;

  logic [AddrW-1:0]           mem_addr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;
  logic [tcw_pkg::CELL_W-1:0] mem_rdata;

  logic [OutCurW-1:0]          res_cursor_q;
  logic [tcw_pkg::CH_W-1:0]    res_char_q;
  logic [tcw_pkg::COLOR_W-1:0] res_fg_q;
  logic [tcw_pkg::COLOR_W-1:0] res_bg_q;

  always_comb begin
    cursor_d = cursor_q;
    row_d    = row_q;
    col_d    = col_q;
    case (ctrl_i.cur_op)
      tcw_pkg::CUR_ADVANCE: begin
        cursor_d = cursor_q + CurW'(1);
        if (col_q == ColW'(Columns - 1)) begin
          col_d = '0;
          row_d = row_q + CurW'(Columns);
        end else begin
          col_d = col_q + ColW'(1);
        end
      end
      tcw_pkg::CUR_NEWLINE: begin
        cursor_d = row_q + CurW'(Columns);
        row_d    = row_q + CurW'(Columns);
        col_d    = '0;
      end
      tcw_pkg::CUR_HOME: begin
        cursor_d = '0;
        row_d    = '0;
        col_d    = '0;
      end
      tcw_pkg::CUR_LAST_ROW: begin
        cursor_d = CurW'(LastRow);
        row_d    = CurW'(LastRow);
        col_d    = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (ctrl_i.cnt_op)
      tcw_pkg::CNT_CLEAR: cnt_d = '0;
      tcw_pkg::CNT_INC:   cnt_d = cnt_q + AddrW'(1);
      default:            cnt_d = cnt_q;
    endcase
  end

  always_comb begin
    case (ctrl_i.addr_sel)
      tcw_pkg::AS_CURSOR:    mem_addr = cursor_q[AddrW-1:0];
      tcw_pkg::AS_COUNT:     mem_addr = cnt_q;
      // source row of the scroll copy
      tcw_pkg::AS_COUNT_ROW: mem_addr = cnt_q + AddrW'(Columns);
      tcw_pkg::AS_READ:      mem_addr = raddr_q;
      default:               mem_addr = cnt_q;
    endcase
  end

  always_comb begin
    case (ctrl_i.wdata_sel)
      tcw_pkg::WD_CHAR:  mem_wdata = {bg_i, fg_i, ch_q};
      tcw_pkg::WD_SPACE: mem_wdata = {bg_i, fg_i, tcw_pkg::SPACE_CODE};
      tcw_pkg::WD_ZERO:  mem_wdata = '0;
      tcw_pkg::WD_COPY:  mem_wdata = mem_rdata;
      default:           mem_wdata = '0;
    endcase
  end

  tcw_cell_ram #(
    .Depth (Cells),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.mem_we),
    .re_i    (ctrl_i.mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      row_q    <= '0;
      col_q    <= '0;
      cnt_q    <= '0;
    end else begin
      cursor_q <= cursor_d;
      row_q    <= row_d;
      col_q    <= col_d;
      cnt_q    <= cnt_d;
    end
  end

  // command operands and result word
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      ch_q    <= in_ch_i;
      raddr_q <= AddrW'(in_read_addr_i);
      rd_ok_q <= 32'(in_read_addr_i) < 32'(Cells);
    end
    if (ctrl_i.res_load) begin
      res_cursor_q <= OutCurW'(cursor_d);
      if (ctrl_i.res_cell && rd_ok_q) begin
        res_char_q <= mem_rdata[7:0];
        res_fg_q   <= mem_rdata[11:8];
        res_bg_q   <= mem_rdata[15:12];
      end else begin
        res_char_q <= '0;
        res_fg_q   <= '0;
        res_bg_q   <= '0;
      end
    end
  end

  assign stat_o.at_last_cell = (cursor_q == CurW'(Cells - 1));
  assign stat_o.on_last_row  = (row_q == CurW'(LastRow));
  assign stat_o.copy_end     = (cnt_q == AddrW'(LastRow - 1));
  assign stat_o.fill_end     = (cnt_q == AddrW'(Cells - 1));

  assign cursor_out_o = res_cursor_q;
  assign cell_char_o  = res_char_q;
  assign cell_fg_o    = res_fg_q;
  assign cell_bg_o    = res_bg_q;

`ifndef ASSERT_OFF
  // cursor always equals row start plus column
  a_cursor_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q == row_q + CurW'(col_q))
    else $error("cursor out of step with row and column");
  // between items the cursor lies on the screen
  a_cursor_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.busy |-> (cursor_q < CurW'(Cells)))
    else $error("cursor beyond screen while idle");
`endif

endmodule
